// ===== rtl/rpms_pkg.sv =====
// ----------------------------------------------------------------------------
// rpms_pkg
// Types, constants and ROM contents shared by the rhythm pattern sequencer.
// ----------------------------------------------------------------------------
package rpms_pkg;

    localparam int STEP_W  = 4;
    localparam int PATCH_W = 4;
    localparam int SEL_W   = 4;
    localparam int CV_W    = 15;
    localparam int MAG_W   = 14;
    localparam int PAT_W   = 16;
    localparam int MUL_W   = 19;
    localparam int PROD_W  = 2 * MUL_W;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 4;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_BANK    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIME   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FACTOR1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FACTOR2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FACTOR3 = 3'd4;

    // Control voltage full scale in millivolts.
    localparam logic signed [CV_W-1:0] CV_POS_LIMIT = 15'sd10000;
    localparam logic [MAG_W-1:0]       CV_MAG_LIMIT = 14'd10000;

    // Division by 10000 as a multiply by ceil(2^32 / 10000) and a shift by 32.
    // Exact for every product of a patch and a voltage up to full scale.
    localparam logic [MUL_W-1:0] RECIP_MULT  = 19'd429497;
    localparam int               RECIP_SHIFT = 32;

    localparam logic [PAT_W-1:0] MASK_ONE   = 16'hFFFF;
    localparam logic [PAT_W-1:0] MASK_TWO   = 16'h0F0F;
    localparam logic [PAT_W-1:0] MASK_THREE = 16'hF003;

    localparam logic [PAT_W-1:0] PATTERN_ROM [32] = '{
        16'h8888, 16'h888A, 16'h8892, 16'h8894, 16'h88A2, 16'h88A4, 16'h8912, 16'h8914,
        16'h8922, 16'h8924, 16'h8A8A, 16'h8AAA, 16'h9292, 16'h92AA, 16'h94AA, 16'h952A,
        16'h8282, 16'h828A, 16'h8292, 16'h82A2, 16'h8484, 16'h848A, 16'h8492, 16'h8494,
        16'h84A2, 16'h84A4, 16'h850A, 16'h8512, 16'h8514, 16'h8522, 16'h8524, 16'h8544
    };

    localparam logic [SEL_W-1:0] FACTOR_ROM [16] = '{
        4'd1, 4'd2, 4'd4, 4'd8, 4'd0, 4'd3, 4'd6, 4'd9,
        4'd12, 4'd5, 4'd10, 4'd15, 4'd7, 4'd14, 4'd11, 4'd13
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CV_MUL,
        ST_RECIP_MUL,
        ST_PATCH,
        ST_F1_MUL,
        ST_F2_MUL,
        ST_F3_MUL,
        ST_DONE
    } t_state;

    // Factor table lookup; entry four is the factor sixteen.
    function automatic logic [MUL_W-1:0] factor_of(input logic [SEL_W-1:0] sel);
        logic [MUL_W-1:0] f;
        if (sel == 4'd4) begin
            f = 19'd16;
        end else begin
            f = {{(MUL_W-SEL_W){1'b0}}, FACTOR_ROM[sel]};
        end
        return f;
    endfunction

    // Folds a product into sixteen bits as low half OR the next four bits.
    function automatic logic [PAT_W-1:0] fold_product(input logic [PROD_W-1:0] p);
        return p[PAT_W-1:0] | {{(PAT_W-4){1'b0}}, p[PAT_W+3:PAT_W]};
    endfunction

endpackage

// ===== rtl/rpms_mul.sv =====
// ----------------------------------------------------------------------------
// rpms_mul
// Shared unsigned multiplier with a registered product and a load enable.
// ----------------------------------------------------------------------------
module rpms_mul (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [rpms_pkg::MUL_W-1:0]   i_a,
    input  logic [rpms_pkg::MUL_W-1:0]   i_b,
    output logic [rpms_pkg::PROD_W-1:0]  o_prod
);

    logic [rpms_pkg::PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= rpms_pkg::PROD_W'(i_a) * rpms_pkg::PROD_W'(i_b);
        end
    end

    assign o_prod = r_prod;

endmodule

// ===== rtl/rhythm_pattern_multiplier_sequencer.sv =====
// ----------------------------------------------------------------------------
// rhythm_pattern_multiplier_sequencer
// Step sequencer that gates a clock with a ROM rhythm pattern and three
// multiplied variants of it, with control voltage scaling of the patch.
// ----------------------------------------------------------------------------
//  channel  | direction | content
//  s        | in        | tick: clock/reset levels, connection flags, cv
//  m        | out       | four gates, step position, effective patch
//  cfg      | in        | register writes, index 0..4
//
//  For each item the sequencer runs five products through the one shared
//  multiplier. The input is ready only while the sequencer is idle; a
//  finished item waits in the output register until taken, and the next
//  item may enter meanwhile. Reset is synchronous and active low; it clears
//  the state, step, edge history, held gates, output valid and configuration.
// ----------------------------------------------------------------------------
module rhythm_pattern_multiplier_sequencer #(
    parameter int STEP_COUNT = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // clock_level, clock_connected, reset_level, cv_connected, cv_millivolts[14:0]
    input  logic [rpms_pkg::IN_DATA_W-1:0]      i_s_tdata,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // prime_gate, product_one_gate, product_two_gate, product_three_gate,
    // step_position[3:0], effective_patch[3:0]
    output logic [rpms_pkg::OUT_DATA_W-1:0]     o_m_tdata,
    input  logic                                i_cfg_we,
    input  logic [rpms_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rpms_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    rpms_pkg::t_state r_state, n_state;

    logic                              r_bank;
    logic [rpms_pkg::PATCH_W-1:0]      r_prime;
    logic [rpms_pkg::SEL_W-1:0]        r_fsel1, r_fsel2, r_fsel3;

    logic [rpms_pkg::STEP_W-1:0]       r_step, n_step;
    logic                              r_prev_clk, n_prev_clk;
    logic                              r_prev_rst, n_prev_rst;
    logic [3:0]                        r_held, n_held;

    logic                              r_clk, r_clk_conn, r_rst, r_cv_pos, r_cv_neg;
    logic [rpms_pkg::MAG_W-1:0]        r_cv_mag;
    logic [rpms_pkg::PATCH_W-1:0]      r_patch, n_patch;
    logic [2:0]                        r_gbits, n_gbits;

    logic                              r_out_valid, n_out_valid;
    logic [rpms_pkg::OUT_DATA_W-1:0]   r_out_data, n_out_data;

    logic                              mul_en;
    logic [rpms_pkg::MUL_W-1:0]        mul_a, mul_b;
    logic [rpms_pkg::PROD_W-1:0]       mul_p;

    logic                              accept;
    logic signed [rpms_pkg::CV_W-1:0]  in_cv;
    logic [rpms_pkg::PAT_W-1:0]        pattern;
    logic [rpms_pkg::PAT_W-1:0]        folded;
    logic [5:0]                        quotient;
    logic [rpms_pkg::STEP_W:0]         step_inc;

    assign accept  = i_s_tvalid && o_s_tready;
    assign in_cv   = $signed(i_s_tdata[rpms_pkg::CV_W+3:4]);
    assign pattern = rpms_pkg::PATTERN_ROM[{r_bank, r_patch}];
    assign folded  = rpms_pkg::fold_product(mul_p);
    assign quotient = mul_p[rpms_pkg::RECIP_SHIFT+5:rpms_pkg::RECIP_SHIFT];
    assign step_inc = {1'b0, r_step} + 5'd1;

    rpms_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (mul_en),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_p)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank  <= 1'b0;
            r_prime <= '0;
            r_fsel1 <= '0;
            r_fsel2 <= '0;
            r_fsel3 <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rpms_pkg::CFG_BANK:    r_bank  <= i_cfg_data[0];
                rpms_pkg::CFG_PRIME:   r_prime <= i_cfg_data;
                rpms_pkg::CFG_FACTOR1: r_fsel1 <= i_cfg_data;
                rpms_pkg::CFG_FACTOR2: r_fsel2 <= i_cfg_data;
                rpms_pkg::CFG_FACTOR3: r_fsel3 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rpms_pkg::ST_IDLE;
            r_step      <= '0;
            r_prev_clk  <= 1'b0;
            r_prev_rst  <= 1'b0;
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_prev_clk  <= n_prev_clk;
            r_prev_rst  <= n_prev_rst;
            r_held      <= n_held;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_clk      <= i_s_tdata[0];
            r_clk_conn <= i_s_tdata[1];
            r_rst      <= i_s_tdata[2];
            r_cv_pos   <= i_s_tdata[3] && (in_cv > 15'sd0);
            r_cv_neg   <= i_s_tdata[3] && (in_cv < 15'sd0);
            r_cv_mag   <= (in_cv > rpms_pkg::CV_POS_LIMIT) ? rpms_pkg::CV_MAG_LIMIT
                                                           : in_cv[rpms_pkg::MAG_W-1:0];
        end
        r_patch    <= n_patch;
        r_gbits    <= n_gbits;
        r_out_data <= n_out_data;
    end

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_prev_clk  = r_prev_clk;
        n_prev_rst  = r_prev_rst;
        n_held      = r_held;
        n_patch     = r_patch;
        n_gbits     = r_gbits;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_data  = r_out_data;
        mul_en      = 1'b0;
        mul_a       = '0;
        mul_b       = '0;
        o_s_tready  = 1'b0;

        unique case (r_state)
            rpms_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    n_state = rpms_pkg::ST_CV_MUL;
                end
            end
            rpms_pkg::ST_CV_MUL: begin
                mul_en  = 1'b1;
                mul_a   = {{(rpms_pkg::MUL_W-rpms_pkg::PATCH_W){1'b0}}, r_prime};
                mul_b   = {{(rpms_pkg::MUL_W-rpms_pkg::MAG_W){1'b0}}, r_cv_mag};
                n_state = rpms_pkg::ST_RECIP_MUL;
            end
            rpms_pkg::ST_RECIP_MUL: begin
                mul_en  = 1'b1;
                mul_a   = mul_p[rpms_pkg::MUL_W-1:0];
                mul_b   = rpms_pkg::RECIP_MULT;
                n_state = rpms_pkg::ST_PATCH;
            end
            rpms_pkg::ST_PATCH: begin
                if (r_cv_neg) begin
                    n_patch = '0;
                end else if (r_cv_pos) begin
                    n_patch = (quotient > {2'b00, r_prime}) ? r_prime
                                                           : quotient[rpms_pkg::PATCH_W-1:0];
                end else begin
                    n_patch = r_prime;
                end
                if (r_clk_conn) begin
                    if (r_clk && !r_prev_clk) begin
                        n_step = (step_inc >= 5'(STEP_COUNT)) ? '0
                                                              : step_inc[rpms_pkg::STEP_W-1:0];
                    end
                    if (r_rst && !r_prev_rst) begin
                        n_step = '0;
                    end
                    n_prev_clk = r_clk;
                    n_prev_rst = r_rst;
                end
                n_state = rpms_pkg::ST_F1_MUL;
            end
            rpms_pkg::ST_F1_MUL: begin
                mul_en     = 1'b1;
                mul_a      = {3'b000, pattern & rpms_pkg::MASK_ONE};
                mul_b      = rpms_pkg::factor_of(r_fsel1);
                n_gbits[0] = pattern[r_step];
                n_state    = rpms_pkg::ST_F2_MUL;
            end
            rpms_pkg::ST_F2_MUL: begin
                mul_en     = 1'b1;
                mul_a      = {3'b000, pattern & rpms_pkg::MASK_TWO};
                mul_b      = rpms_pkg::factor_of(r_fsel2);
                n_gbits[1] = folded[r_step];
                n_state    = rpms_pkg::ST_F3_MUL;
            end
            rpms_pkg::ST_F3_MUL: begin
                mul_en     = 1'b1;
                mul_a      = {3'b000, pattern & rpms_pkg::MASK_THREE};
                mul_b      = rpms_pkg::factor_of(r_fsel3);
                n_gbits[2] = folded[r_step];
                n_state    = rpms_pkg::ST_DONE;
            end
            rpms_pkg::ST_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    if (r_clk_conn) begin
                        n_held = r_clk ? {folded[r_step], r_gbits} : 4'b0000;
                    end
                    n_out_valid = 1'b1;
                    n_out_data  = {4'b0000, r_patch, r_step,
                                   (r_clk_conn ? (r_clk ? {folded[r_step], r_gbits} : 4'b0000)
                                               : r_held)};
                    n_state     = rpms_pkg::ST_IDLE;
                end
            end
            default: n_state = rpms_pkg::ST_IDLE;
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> (r_state == rpms_pkg::ST_IDLE))
        else $error("input ready outside idle");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_step} < 5'(STEP_COUNT)))
        else $error("step counter out of range");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == rpms_pkg::ST_CV_MUL))
        else $error("accepted item did not start the sequencer");

    a_done_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rpms_pkg::ST_DONE && (!r_out_valid || i_m_tready)) |=> o_m_tvalid)
        else $error("finished item not presented");
`endif

endmodule
